### src/pdp_pkg.sv
package pdp_pkg;

   // palette geometry
   localparam int PALETTE_ENTRIES_DEF = 256;
   localparam int INDEX_SPAN = 256;
   localparam int COMPONENTS = 3;
   localparam int COLOR_W = 24;

   // component counter runs 0..2
   localparam logic [1:0] FIRST_SLOT = 2'd0;
   localparam logic [1:0] LAST_SLOT = 2'(COMPONENTS - 1);

   localparam logic [7:0] MASK_RESET = 8'hFF;

   // access kind carried in tuser bit 0
   localparam logic CMD_READ = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // register select carried in tuser bits 2..1
   localparam logic [1:0] REG_WRITE_INDEX = 2'd0;
   localparam logic [1:0] REG_PIXEL_MASK = 2'd1;
   localparam logic [1:0] REG_READ_INDEX = 2'd2;
   localparam logic [1:0] REG_COLOR_DATA = 2'd3;

   // request from the control unit to the palette store
   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic [7:0] wr_index;
      logic [7:0] rd_index;
      logic [COLOR_W-1:0] wr_color;
   } store_req_type;

endpackage

### src/pdp_store.sv
module pdp_store
   import pdp_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
   input logic clock,
   input logic reset,
   input store_req_type store_req,
   output logic [COLOR_W-1:0] store_rdata
);

   localparam int ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   typedef logic [ADDR_W-1:0] addr_map_type [INDEX_SPAN];

   // 8-bit index folded onto the store depth
   function automatic addr_map_type build_addr_map();
      addr_map_type m;
      int r;
      r = 0;
      for (int i = 0; i < INDEX_SPAN; i++) begin
         m[i] = ADDR_W'(r);
         r = (r + 1 == PALETTE_ENTRIES) ? 0 : r + 1;
      end
      return m;
   endfunction

   localparam addr_map_type ADDR_MAP = build_addr_map();

   logic [COLOR_W-1:0] palette_ff [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] valid_ff;
   logic [COLOR_W-1:0] rd_data_ff;
   logic rd_hit_ff;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;

   assign wr_addr = ADDR_MAP[store_req.wr_index];
   assign rd_addr = ADDR_MAP[store_req.rd_index];

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         palette_ff[wr_addr] <= store_req.wr_color;
      end
      if (store_req.rd_en) begin
         rd_data_ff <= palette_ff[rd_addr];
      end
   end

   // never-written entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         if (store_req.wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (store_req.rd_en) begin
            rd_hit_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign store_rdata = rd_hit_ff ? rd_data_ff : '0;

endmodule

### src/pdp_ctrl.sv
module pdp_ctrl
   import pdp_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   input logic [7:0] req_tdata,
   input logic [2:0] req_tuser,
   output logic rsp_tvalid,
   input logic rsp_tready,
   output logic [7:0] rsp_tdata,
   output store_req_type store_req,
   input logic [COLOR_W-1:0] store_rdata
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LOAD = 1'b1;

   logic state_ff, state_in;
   logic [7:0] write_index_ff, write_index_in;
   logic [7:0] read_index_ff, read_index_in;
   logic [7:0] mask_ff, mask_in;
   logic [1:0] count_ff, count_in;
   logic [7:0] comp_ff [COMPONENTS];
   logic [7:0] comp_in [COMPONENTS];
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;

   logic accept;
   logic cmd;
   logic [1:0] sel;
   logic [7:0] masked;
   logic [7:0] comp_cur;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept = req_tvalid && req_tready;
   assign cmd = req_tuser[0];
   assign sel = req_tuser[2:1];
   assign masked = req_tdata & mask_ff;

   always_comb begin
      case (count_ff)
         2'd0: comp_cur = comp_ff[0];
         2'd1: comp_cur = comp_ff[1];
         default: comp_cur = comp_ff[2];
      endcase
   end

   always_comb begin
      state_in = state_ff;
      write_index_in = write_index_ff;
      read_index_in = read_index_ff;
      mask_in = mask_ff;
      count_in = count_ff;
      for (int i = 0; i < COMPONENTS; i++) begin
         comp_in[i] = comp_ff[i];
      end
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      store_req = '0;
      store_req.wr_index = write_index_ff;
      store_req.rd_index = read_index_ff;
      store_req.wr_color = {comp_ff[0], comp_ff[1], masked};

      if (state_ff == ST_LOAD) begin
         // color back from the store: fill buffer, return first component
         comp_in[0] = store_rdata[23:16];
         comp_in[1] = store_rdata[15:8];
         comp_in[2] = store_rdata[7:0];
         rsp_valid_in = 1'b1;
         rsp_data_in = store_rdata[23:16];
         count_in = FIRST_SLOT + 2'd1;
         state_in = ST_IDLE;
      end else if (accept) begin
         if (cmd == CMD_WRITE) begin
            case (sel)
               REG_WRITE_INDEX: begin
                  write_index_in = req_tdata;
                  count_in = FIRST_SLOT;
               end
               REG_PIXEL_MASK: begin
                  mask_in = req_tdata;
               end
               REG_READ_INDEX: begin
                  read_index_in = req_tdata;
                  count_in = FIRST_SLOT;
               end
               default: begin
                  for (int i = 0; i < COMPONENTS; i++) begin
                     if (count_ff == 2'(i)) begin
                        comp_in[i] = masked;
                     end
                  end
                  if (count_ff == LAST_SLOT) begin
                     store_req.wr_en = 1'b1;
                     write_index_in = write_index_ff + 8'd1;
                     count_in = FIRST_SLOT;
                  end else begin
                     count_in = count_ff + 2'd1;
                  end
               end
            endcase
         end else begin
            case (sel)
               REG_WRITE_INDEX: begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in = write_index_ff;
               end
               REG_PIXEL_MASK: begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in = mask_ff;
               end
               REG_READ_INDEX: begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in = read_index_ff;
               end
               default: begin
                  if (count_ff == FIRST_SLOT) begin
                     store_req.rd_en = 1'b1;
                     state_in = ST_LOAD;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in = comp_cur;
                     if (count_ff == LAST_SLOT) begin
                        read_index_in = read_index_ff + 8'd1;
                        count_in = FIRST_SLOT;
                     end else begin
                        count_in = count_ff + 2'd1;
                     end
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         write_index_ff <= '0;
         read_index_ff <= '0;
         mask_ff <= MASK_RESET;
         count_ff <= FIRST_SLOT;
         for (int i = 0; i < COMPONENTS; i++) begin
            comp_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         write_index_ff <= write_index_in;
         read_index_ff <= read_index_in;
         mask_ff <= mask_in;
         count_ff <= count_in;
         for (int i = 0; i < COMPONENTS; i++) begin
            comp_ff[i] <= comp_in[i];
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("component counter out of range");

   a_load_out_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> !rsp_valid_ff)
      else $error("store load while output register busy");

   a_load_issue: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd == CMD_READ && sel == REG_COLOR_DATA && count_ff == FIRST_SLOT)
      |=> (state_ff == ST_LOAD)) else $error("data read did not wait for store");

   a_load_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |=> (rsp_valid_ff && count_ff == FIRST_SLOT + 2'd1
      && state_ff == ST_IDLE)) else $error("store load did not complete");

endmodule

### src/palette_dac_port.sv
// response: an index, mask or buffered data read shows its word in the cycle after accept
// a data read at component 0 loads the color through the store's registered read
//   port and then the output register before its word shows
// throughput: one word per cycle unless rsp_tready or a load stalls; writes give none
// reset: palette entries read as zero through cleared per-entry valid bits,
//   indexes and counter zero, pixel mask all ones
module palette_dac_port
   import pdp_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
   input logic clock,
   input logic reset,
   // request channel: one register access per word
   input logic req_tvalid,
   output logic req_tready,
   input logic [7:0] req_tdata,   // [7:0] write_data
   input logic [2:0] req_tuser,   // [0] command, [2:1] reg_select
   // response channel: one word per read access
   output logic rsp_tvalid,
   input logic rsp_tready,
   output logic [7:0] rsp_tdata   // [7:0] read_data
);

   // store request and returned color
   store_req_type store_req;
   logic [COLOR_W-1:0] store_rdata;

   // register file, component counter and output register
   pdp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata (rsp_tdata),
      .store_req (store_req),
      .store_rdata (store_rdata)
   );

   // palette memory with a registered read port
   pdp_store #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_store (
      .clock (clock),
      .reset (reset),
      .store_req (store_req),
      .store_rdata (store_rdata)
   );

endmodule

### tb/palette_dac_checker.sv
module palette_dac_checker
   import pdp_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic [7:0] req_tdata,   // [7:0] write_data
   input logic [2:0] req_tuser,   // [0] command, [2:1] reg_select
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [7:0] rsp_tdata,   // [7:0] read_data
   output int fail_count,
   output int pending_count
);

   // shadow copy of the palette and the port registers
   logic [COLOR_W-1:0] shadow_colors [PALETTE_ENTRIES];
   logic [7:0] shadow_wr_index;
   logic [7:0] shadow_rd_index;
   logic [7:0] shadow_mask;
   logic [1:0] shadow_slot;
   logic [7:0] shadow_comp [COMPONENTS];

   logic [7:0] read_bytes_due [$];
   int mismatches = 0;
   int due_count = 0;

   assign fail_count = mismatches;
   assign pending_count = due_count;

   always @(posedge clock) begin : track_port
      logic [1:0] sel;
      logic [7:0] data;
      logic [7:0] want;
      if (reset) begin
         foreach (shadow_colors[i]) shadow_colors[i] = '0;
         foreach (shadow_comp[i]) shadow_comp[i] = '0;
         shadow_wr_index = '0;
         shadow_rd_index = '0;
         shadow_mask = MASK_RESET;
         shadow_slot = FIRST_SLOT;
         read_bytes_due.delete();
      end else begin
         // a word leaving now was asked for at an earlier edge
         if (rsp_tvalid && rsp_tready) begin
            if (read_bytes_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected read word, expected none, actual %02h",
                        $time, rsp_tdata);
            end else begin
               want = read_bytes_due.pop_front();
               if (rsp_tdata !== want) begin
                  mismatches++;
                  $display("%0t: read_data mismatch, expected %02h, actual %02h",
                           $time, want, rsp_tdata);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            sel = req_tuser[2:1];
            data = req_tdata;
            if (req_tuser[0] == CMD_WRITE) begin
               case (sel)
                  REG_WRITE_INDEX: begin
                     shadow_wr_index = data;
                     shadow_slot = FIRST_SLOT;
                  end
                  REG_PIXEL_MASK: shadow_mask = data;
                  REG_READ_INDEX: begin
                     shadow_rd_index = data;
                     shadow_slot = FIRST_SLOT;
                  end
                  default: begin
                     shadow_comp[shadow_slot] = data & shadow_mask;
                     if (shadow_slot == LAST_SLOT) begin
                        shadow_colors[shadow_wr_index % PALETTE_ENTRIES] =
                           {shadow_comp[0], shadow_comp[1], shadow_comp[2]};
                        shadow_wr_index++;
                        shadow_slot = FIRST_SLOT;
                     end else begin
                        shadow_slot++;
                     end
                  end
               endcase
            end else begin
               case (sel)
                  REG_WRITE_INDEX: read_bytes_due.push_back(shadow_wr_index);
                  REG_PIXEL_MASK: read_bytes_due.push_back(shadow_mask);
                  REG_READ_INDEX: read_bytes_due.push_back(shadow_rd_index);
                  default: begin
                     // only a read at the first slot fetches from the store
                     if (shadow_slot == FIRST_SLOT)
                        {shadow_comp[0], shadow_comp[1], shadow_comp[2]} =
                           shadow_colors[shadow_rd_index % PALETTE_ENTRIES];
                     read_bytes_due.push_back(shadow_comp[shadow_slot]);
                     if (shadow_slot == LAST_SLOT) begin
                        shadow_rd_index++;
                        shadow_slot = FIRST_SLOT;
                     end else begin
                        shadow_slot++;
                     end
                  end
               endcase
            end
         end
      end
      due_count = read_bytes_due.size();
   end

endmodule

### tb/tb_palette_dac_port.sv
module tb_palette_dac_port;
   import pdp_pkg::*;

   // total words offered, directed part included
   localparam int WORD_TARGET = 1775;
   // idling stops for the tail of the run
   localparam int QUIET_FROM = 1550;
   // the long receiver hold is triggered once this many words went in
   localparam int HOLD_AT = 700;
   localparam int HOLD_CYCLES = 90;
   localparam int HOLD_BURST = 64;
   // cycles with no word moving on either channel before the run is declared hung
   localparam int STALL_LIMIT = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid;
   logic req_tready;
   logic [7:0] req_tdata;   // [7:0] write_data
   logic [2:0] req_tuser;   // [0] command, [2:1] reg_select
   logic rsp_tvalid;
   logic rsp_tready;
   logic [7:0] rsp_tdata;   // [7:0] read_data

   int fail_count;
   int pending_count;
   int words_sent = 0;
   bit quiet = 1'b0;          // no idling on either side
   bit steady_offer = 1'b0;   // sender offers back to back
   bit want_hold = 1'b0;      // asks the receiver for its long hold

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   palette_dac_port dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   palette_dac_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   // offer one register access, optionally after an idle burst, and wait
   // until the port takes it
   task automatic send_word(input logic cmd, input logic [1:0] sel,
                            input logic [7:0] data);
      int unsigned gap;
      if (!quiet && !steady_offer && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 14);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= {sel, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   // indexes cluster in a low window and around the wrap point so that
   // readback often lands on entries filled earlier
   function automatic logic [7:0] pick_index();
      case ($urandom_range(0, 3))
         0, 1: return 8'($urandom_range(0, 7));
         2: return 8'($urandom_range(248, 255));
         default: return 8'($urandom);
      endcase
   endfunction

   // receiver: mostly ready, random stall bursts, one long hold
   initial begin : rsp_side
      int unsigned span;
      bit hold_served;
      hold_served = 1'b0;
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         if (want_hold && !hold_served) begin
            // long hold so the port backs up and drops req_tready
            hold_served = 1'b1;
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
            end
         end else if (quiet || $urandom_range(0, 11) != 0) begin
            @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            span = $urandom_range(1, 14);
            repeat (span) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
            end
         end
      end
   end

   // watchdog: ends the run when nothing moves on either channel
   initial begin : watchdog
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("palette_dac_port verification failed");
      $finish;
   end

   initial begin : stimulus
      int unsigned n;
      logic [7:0] m;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed: registers straight after reset
      send_word(CMD_READ, REG_WRITE_INDEX, 8'h00);
      send_word(CMD_READ, REG_PIXEL_MASK, 8'hFF);
      send_word(CMD_READ, REG_READ_INDEX, 8'h00);
      send_word(CMD_READ, REG_COLOR_DATA, 8'hFF);   // cleared entry 0
      // fill the top entry, write index wraps to zero
      send_word(CMD_WRITE, REG_WRITE_INDEX, 8'hFF);
      send_word(CMD_WRITE, REG_COLOR_DATA, 8'hFF);
      send_word(CMD_WRITE, REG_COLOR_DATA, 8'h00);
      send_word(CMD_WRITE, REG_COLOR_DATA, 8'hA5);
      send_word(CMD_READ, REG_WRITE_INDEX, 8'h00);
      // partial masked write, then data reads pick up the shared buffer
      send_word(CMD_WRITE, REG_PIXEL_MASK, 8'h0F);
      send_word(CMD_WRITE, REG_COLOR_DATA, 8'hFF);
      send_word(CMD_READ, REG_COLOR_DATA, 8'h00);
      send_word(CMD_READ, REG_COLOR_DATA, 8'h00);
      // read back the top entry, mask must not touch read data
      send_word(CMD_WRITE, REG_READ_INDEX, 8'hFF);
      send_word(CMD_READ, REG_COLOR_DATA, 8'h00);
      send_word(CMD_READ, REG_COLOR_DATA, 8'h00);
      send_word(CMD_READ, REG_COLOR_DATA, 8'h00);
      send_word(CMD_READ, REG_READ_INDEX, 8'h00);
      // zero mask blanks written data
      send_word(CMD_WRITE, REG_PIXEL_MASK, 8'h00);
      send_word(CMD_WRITE, REG_COLOR_DATA, 8'h5A);
      send_word(CMD_READ, REG_PIXEL_MASK, 8'h00);
      send_word(CMD_WRITE, REG_PIXEL_MASK, 8'hFF);
      send_word(CMD_WRITE, REG_WRITE_INDEX, 8'h00);

      // random: mostly whole fill and readback runs, some noise and
      // broken runs that leave the component counter mid-way
      while (words_sent < WORD_TARGET) begin
         quiet = (words_sent >= QUIET_FROM);
         if (!want_hold && words_sent >= HOLD_AT) begin
            want_hold = 1'b1;
            steady_offer = 1'b1;
            repeat (HOLD_BURST)
               send_word(CMD_READ, 2'($urandom_range(0, 3)), 8'($urandom));
            steady_offer = 1'b0;
         end
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               // fill one to four palette entries
               send_word(CMD_WRITE, REG_WRITE_INDEX, pick_index());
               n = $urandom_range(1, 4);
               repeat (3 * n) send_word(CMD_WRITE, REG_COLOR_DATA, 8'($urandom));
            end
            3, 4, 5: begin
               // read back one to four entries
               send_word(CMD_WRITE, REG_READ_INDEX, pick_index());
               n = $urandom_range(1, 4);
               repeat (3 * n) send_word(CMD_READ, REG_COLOR_DATA, 8'($urandom));
            end
            6: begin
               // pixel mask, mostly all ones
               case ($urandom_range(0, 5))
                  0: m = 8'h00;
                  1, 2: m = 8'($urandom);
                  default: m = MASK_RESET;
               endcase
               send_word(CMD_WRITE, REG_PIXEL_MASK, m);
            end
            7: begin
               n = $urandom_range(1, 3);
               repeat (n) send_word(CMD_READ, 2'($urandom_range(0, 2)), 8'($urandom));
            end
            8: begin
               n = $urandom_range(1, 6);
               repeat (n) send_word(1'($urandom), 2'($urandom), 8'($urandom));
            end
            default: begin
               // partial color transfer, mixing reads and writes of data
               send_word(CMD_WRITE, REG_COLOR_DATA, 8'($urandom));
               n = $urandom_range(1, 4);
               repeat (n) send_word(1'($urandom), REG_COLOR_DATA, 8'($urandom));
               if ($urandom_range(0, 1) == 0)
                  send_word(CMD_WRITE, 2'($urandom_range(0, 1)) << 1, pick_index());
            end
         endcase
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      // drain outstanding reads, then allow for the load latency
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("palette_dac_port verification clean");
      else
         $display("palette_dac_port verification failed");
      $finish;
   end

endmodule
